FILE: rtl/core/mtsp_pkg.sv
// ----------------------------------------------------------------------------
// mtsp_pkg
// Shared widths, constants and types of the motion time scaling profile core.
// ----------------------------------------------------------------------------
package mtsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 4;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int TA_W      = FRAC_BITS;
  localparam int PADDR_W   = 3;
  localparam int CR_W      = T_W + 1;

  localparam logic [T_W-1:0]  ONE_Q       = T_W'(1) << FRAC_BITS;
  localparam logic [TA_W-1:0] TA_MIN      = TA_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [TA_W-1:0] TA_MAX      = TA_W'((49 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic [TA_W-1:0] ACCEL_RESET = TA_W'((1 << FRAC_BITS) / 4);

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_ACCEL = 1'b1;

  typedef enum logic [1:0] {
    MODE_LINEAR    = 2'd0,
    MODE_MIN_JERK  = 2'd1,
    MODE_TRAPEZOID = 2'd2
  } profile_mode_t;

  typedef enum logic [1:0] {
    SEG_RISE   = 2'd0,
    SEG_CRUISE = 2'd1,
    SEG_FALL   = 2'd2
  } seg_t;

  typedef struct packed {
    logic            trap;
    seg_t            seg;
    logic [T_W-1:0]  base;
    logic [CR_W-1:0] cr;
  } side1_t;

  typedef struct packed {
    logic           trap;
    seg_t           seg;
    logic [T_W-1:0] base;
  } side2_t;

endpackage

FILE: rtl/core/mtsp_stream_if.sv
// ----------------------------------------------------------------------------
// mtsp_stream_if
// Valid/ready channels for time samples and progress results.
// ----------------------------------------------------------------------------
interface mtsp_time_if import mtsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [IN_W-1:0] norm_time;

  modport source (output valid, output norm_time, input ready);
  modport sink   (input valid, input norm_time, output ready);
endinterface

interface mtsp_prog_if import mtsp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [T_W-1:0] progress;

  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

FILE: rtl/core/mtsp_div_pipe.sv
// ----------------------------------------------------------------------------
// mtsp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module mtsp_div_pipe #(
  parameter int  NUM_W  = 30,
  parameter int  DEN_W  = 17,
  parameter int  QUO_W  = 15,
  parameter type SIDE_T = logic
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  SIDE_T            in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output SIDE_T            out_side
);

  localparam int CW = NUM_W + DEN_W + QUO_W;

  logic             vld  [QUO_W];
  logic [QUO_W-1:0] quo  [QUO_W];
  SIDE_T            side [QUO_W];
  logic [NUM_W-1:0] rem  [QUO_W-1];
  logic [DEN_W-1:0] den  [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;

    logic             vld_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    SIDE_T            side_in;
    logic [CW-1:0]    trial;
    logic [CW-1:0]    diff;
    logic             ge;

    if (k == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld[k-1];
      assign rem_in  = rem[k-1];
      assign den_in  = den[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
    end

    assign trial = CW'(den_in) << B;
    assign ge    = CW'(rem_in) >= trial;
    assign diff  = CW'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k]  <= ge ? (quo_in | (QUO_W'(1) << B)) : quo_in;
        side[k] <= side_in;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? diff[NUM_W-1:0] : rem_in;
          den[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = quo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

FILE: rtl/core/motion_time_scaling_profile_core.sv
// ----------------------------------------------------------------------------
// motion_time_scaling_profile_core
// Maps a normalized time sample to path progress: linear, minimum jerk or
// trapezoidal velocity profile.
//
// sample carries one signed Q16 time per item; result returns one unsigned
// Q16 progress value per item, in order. Both use valid/ready.
// profile_mode sits at byte address 0, accel_fraction at byte address 4 of
// the APB port; pready is always high and reads return the register value.
// Write the registers only while no item is in flight.
// A result passes through five arithmetic stages, a 15-stage divider
// for x*x/(1-ta), a 16-stage divider for the cruise slope and parabola
// scaling, and the output register. Throughput: one item per cycle
// while results are taken, set by the fully pipelined dividers.
// A stalled result freezes the whole pipeline, ready drops while it waits,
// and nothing is lost or repeated. Reset empties the pipeline and sets the
// mode to linear and the acceleration share to one quarter.
// ----------------------------------------------------------------------------
module motion_time_scaling_profile_core import mtsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  mtsp_time_if.sink          sample,
  mtsp_prog_if.source        result
);

  localparam int SQ_W  = 2 * T_W;
  localparam int S6_W  = SQ_W + 3;
  localparam int PX_W  = FRAC_BITS + 5;
  localparam int P_W   = FRAC_BITS + 4;
  localparam int MJ_W  = T_W + P_W;
  localparam int N1_W  = 2 * (FRAC_BITS - 1);
  localparam int Q1_W  = FRAC_BITS - 1;
  localparam int N2_W  = CR_W + FRAC_BITS;
  localparam int D2_W  = T_W + 1;
  localparam int Q2_W  = FRAC_BITS;
  localparam int P_TEN = 10 * (1 << FRAC_BITS);

  logic [1:0]      mode;
  logic [TA_W-1:0] accel;
  logic [TA_W-1:0] ta;
  logic [T_W-1:0]  one_m_ta;
  logic            en;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_LINEAR;
      accel <= ACCEL_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ACCEL) begin
        accel <= pwdata[TA_W-1:0];
      end else begin
        mode <= pwdata[1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACCEL) ? 32'(accel) : 32'(mode);

  always_comb begin
    if (accel < TA_MIN) begin
      ta = TA_MIN;
    end else if (accel > TA_MAX) begin
      ta = TA_MAX;
    end else begin
      ta = accel;
    end
  end

  assign one_m_ta = ONE_Q - T_W'(ta);

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // stage 1: clamp time
  logic [T_W-1:0] t_in;
  logic           s1_valid;
  logic [T_W-1:0] s1_t;

  always_comb begin
    if (sample.norm_time[IN_W-1]) begin
      t_in = '0;
    end else if (sample.norm_time[IN_W-2:0] > (IN_W-1)'(ONE_Q)) begin
      t_in = ONE_Q;
    end else begin
      t_in = sample.norm_time[T_W-1:0];
    end
  end

  // stage 2: segment and square operand
  seg_t           seg;
  logic [T_W-1:0] x;
  logic           s2_valid;
  logic [T_W-1:0] s2_t;
  seg_t           s2_seg;
  logic [T_W-1:0] s2_x;

  always_comb begin
    if (s1_t <= T_W'(ta)) begin
      seg = SEG_RISE;
    end else if (s1_t <= one_m_ta) begin
      seg = SEG_CRUISE;
    end else begin
      seg = SEG_FALL;
    end
    x = s1_t;
    if (mode == MODE_TRAPEZOID) begin
      case (seg)
        SEG_RISE: x = s1_t;
        SEG_FALL: x = ONE_Q - s1_t;
        default:  x = '0;
      endcase
    end
  end

  // stage 3: square
  logic            s3_valid;
  logic [T_W-1:0]  s3_t;
  seg_t            s3_seg;
  logic [SQ_W-1:0] s3_sq;

  // stage 4: cube and polynomial, divider operands
  logic [SQ_W-1:0] mj_cube;
  logic [S6_W-1:0] sq6;
  logic [PX_W-1:0] t15;
  logic [PX_W-1:0] p_full;
  logic            s4_valid;
  logic [T_W-1:0]  s4_t;
  seg_t            s4_seg;
  logic [T_W-1:0]  s4_t3;
  logic [P_W-1:0]  s4_p;
  logic [N1_W-1:0] s4_n1;
  logic [CR_W-1:0] s4_cr;

  assign mj_cube = SQ_W'(s3_sq[FRAC_BITS +: T_W]) * SQ_W'(s3_t);
  assign sq6     = (S6_W'(s3_sq) << 2) + (S6_W'(s3_sq) << 1);
  assign t15     = (PX_W'(s3_t) << 4) - PX_W'(s3_t);
  assign p_full  = PX_W'(P_TEN) + sq6[FRAC_BITS +: PX_W] - t15;

  // stage 5: minimum jerk product and base result
  logic [MJ_W-1:0] mj_prod;
  logic [T_W-1:0]  mj_sat;
  logic            s5_valid;
  logic [N1_W-1:0] s5_n1;
  side1_t          s5_side;

  assign mj_prod = MJ_W'(s4_t3) * MJ_W'(s4_p);
  assign mj_sat  = (mj_prod[FRAC_BITS +: PX_W] > PX_W'(ONE_Q)) ? ONE_Q
                                                               : mj_prod[FRAC_BITS +: T_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t         <= t_in;
      s2_t         <= s1_t;
      s2_seg       <= seg;
      s2_x         <= x;
      s3_t         <= s2_t;
      s3_seg       <= s2_seg;
      s3_sq        <= SQ_W'(s2_x) * SQ_W'(s2_x);
      s4_t         <= s3_t;
      s4_seg       <= s3_seg;
      s4_t3        <= mj_cube[FRAC_BITS +: T_W];
      s4_p         <= p_full[P_W-1:0];
      s4_n1        <= s3_sq[N1_W-1:0];
      s4_cr        <= {s3_t, 1'b0} - CR_W'(ta);
      s5_n1        <= s4_n1;
      s5_side.trap <= (mode == MODE_TRAPEZOID);
      s5_side.seg  <= s4_seg;
      s5_side.base <= (mode == MODE_MIN_JERK) ? mj_sat : s4_t;
      s5_side.cr   <= s4_cr;
    end
  end

  // x*x / (1 - ta)
  logic            d1_valid;
  logic [Q1_W-1:0] d1_quo;
  side1_t          d1_side;

  mtsp_div_pipe #(
    .NUM_W  (N1_W),
    .DEN_W  (T_W),
    .QUO_W  (Q1_W),
    .SIDE_T (side1_t)
  ) u_div_sq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .in_num    (s5_n1),
    .in_den    (one_m_ta),
    .in_side   (s5_side),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // parabola scaling by 1/(2ta) or cruise slope by 1/(2(1-ta))
  logic [N2_W-1:0] d2_num;
  logic [D2_W-1:0] d2_den;
  side2_t          d2_in_side;
  logic            d2_valid;
  logic [Q2_W-1:0] d2_quo;
  side2_t          d2_side;

  always_comb begin
    d2_in_side.trap = d1_side.trap;
    d2_in_side.seg  = d1_side.seg;
    d2_in_side.base = d1_side.base;
    d2_den          = {one_m_ta, 1'b0};
    if (!d1_side.trap) begin
      d2_num = '0;
    end else if (d1_side.seg == SEG_CRUISE) begin
      d2_num = {d1_side.cr, {FRAC_BITS{1'b0}}};
    end else begin
      d2_num = N2_W'({d1_quo, {FRAC_BITS{1'b0}}});
      d2_den = {1'b0, ta, 1'b0};
    end
  end

  mtsp_div_pipe #(
    .NUM_W  (N2_W),
    .DEN_W  (D2_W),
    .QUO_W  (Q2_W),
    .SIDE_T (side2_t)
  ) u_div_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .in_side   (d2_in_side),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // output register
  logic [T_W-1:0] res;

  always_comb begin
    if (!d2_side.trap) begin
      res = d2_side.base;
    end else if (d2_side.seg == SEG_FALL) begin
      res = ONE_Q - T_W'(d2_quo);
    end else begin
      res = T_W'(d2_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.progress <= res;
    end
  end

endmodule

FILE: tb/motion_time_scaling_profile_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_time_scaling_profile_core_test
// Streams time samples through the profile core under every profile mode and
// a range of acceleration shares, and compares each progress item with a
// local fixed point model of the three time-scaling laws. A directed table
// covers clamping, extremes and register masking; random phases follow,
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module motion_time_scaling_profile_core_test;
  import mtsp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 45;
  localparam int STEP_COUNT   = 25;

  typedef struct packed {
    logic [31:0]     mode_wr;
    logic [31:0]     accel_wr;
    logic [IN_W-1:0] stamp;
    logic            known;
    logic [T_W-1:0]  want;
  } step_row_t;

  localparam step_row_t STEPS [STEP_COUNT] = '{
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h00000, 1'b1, 17'd0},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h10000, 1'b1, 17'd65536},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h80000, 1'b1, 17'd0},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h7ffff, 1'b1, 17'd65536},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'hfffff, 1'b1, 17'd0},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h10001, 1'b1, 17'd65536},
    '{32'(MODE_LINEAR), 32'(ACCEL_RESET), 20'h08000, 1'b1, 17'd32768},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'h00000, 1'b1, 17'd0},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'h10000, 1'b1, 17'd65536},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'h08000, 1'b1, 17'd32768},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'h7ffff, 1'b1, 17'd65536},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'h80000, 1'b1, 17'd0},
    '{32'(MODE_MIN_JERK), 32'(ACCEL_RESET), 20'd13107, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'(ACCEL_RESET), 20'h00000, 1'b1, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'(ACCEL_RESET), 20'h10000, 1'b1, 17'd65536},
    '{32'(MODE_TRAPEZOID), 32'(ACCEL_RESET), 20'd16384, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'(ACCEL_RESET), 20'd32768, 1'b1, 17'd32768},
    '{32'(MODE_TRAPEZOID), 32'(ACCEL_RESET), 20'd50000, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'd0, 20'd655, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'd0, 20'd30000, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'd65535, 20'd32113, 1'b0, 17'd0},
    '{32'(MODE_TRAPEZOID), 32'd65535, 20'd40000, 1'b0, 17'd0},
    '{32'(MODE_UNUSED), 32'(ACCEL_RESET), 20'd40000, 1'b1, 17'd40000},
    '{32'hffff_fff9, 32'habcd_4000, 20'd32768, 1'b1, 17'd32768},
    '{32'hffff_fffa, 32'h1234_4000, 20'd32768, 1'b1, 17'd32768}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  mtsp_time_if sample_ch ();
  mtsp_prog_if result_ch ();

  motion_time_scaling_profile_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  always #4 clk = ~clk;

  logic [T_W-1:0]  progress_q [$];
  logic [1:0]      cur_mode;
  logic [TA_W-1:0] cur_accel;
  logic [31:0]     last_mode_wr;
  logic [31:0]     last_accel_wr;
  logic            sender_idle;
  logic            receiver_idle;
  int              long_hold = 0;
  int              errors = 0;
  int              cycles = 0;
  int              row;
  int              phase;
  int              item;
  logic [1:0]      pick_mode;
  logic [TA_W-1:0] pick_accel;
  logic [31:0]     wr_word;

  function automatic longint unsigned parabola_rise(input longint unsigned x,
                                                    input longint unsigned ta);
    longint unsigned one;
    longint unsigned q;
    one = 64'd1 << FRAC_BITS;
    q = (x * x) / (one - ta);
    return (q * one) / (2 * ta);
  endfunction

  function automatic logic [T_W-1:0] scale_time(input logic [IN_W-1:0] raw,
                                                input logic [1:0] mode,
                                                input logic [TA_W-1:0] accel);
    longint unsigned one, t, s, t2, t3, p, ta, f;
    one = 64'd1 << FRAC_BITS;
    if (raw[IN_W-1]) t = 0;
    else if (64'(raw) > one) t = one;
    else t = 64'(raw);
    if (mode == MODE_MIN_JERK) begin
      t2 = (t * t) >> FRAC_BITS;
      t3 = (t2 * t) >> FRAC_BITS;
      p = 10 * one + ((6 * t * t) >> FRAC_BITS) - 15 * t;
      s = (t3 * p) >> FRAC_BITS;
    end else if (mode == MODE_TRAPEZOID) begin
      ta = 64'(accel);
      if (ta < 64'(TA_MIN)) ta = 64'(TA_MIN);
      if (ta > 64'(TA_MAX)) ta = 64'(TA_MAX);
      if (t <= ta) begin
        s = parabola_rise(t, ta);
      end else if (t <= one - ta) begin
        s = ((2 * t - ta) * one) / (2 * (one - ta));
      end else begin
        f = parabola_rise(one - t, ta);
        s = (f >= one) ? 0 : one - f;
      end
    end else begin
      s = t;
    end
    if (s > one) s = one;
    return s[T_W-1:0];
  endfunction

  // mostly in-range times, some near the segment joints, some anywhere
  function automatic logic [IN_W-1:0] pick_time();
    logic [TA_W-1:0] ta;
    ta = cur_accel;
    if (ta < TA_MIN) ta = TA_MIN;
    if (ta > TA_MAX) ta = TA_MAX;
    case ($urandom_range(0, 9))
      0: return IN_W'($urandom());
      1: begin
        case ($urandom_range(0, 9))
          0: return IN_W'(int'(ta) - 1);
          1: return IN_W'(ta);
          2: return IN_W'(int'(ta) + 1);
          3: return IN_W'(int'(ONE_Q) - int'(ta) - 1);
          4: return IN_W'(ONE_Q) - IN_W'(ta);
          5: return IN_W'(int'(ONE_Q) - int'(ta) + 1);
          6: return '0;
          7: return IN_W'(ONE_Q);
          8: return IN_W'(int'(ONE_Q) + 1);
          default: return {IN_W{1'b1}};
        endcase
      end
      default: return IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_time(input logic [IN_W-1:0] stamp, input logic known,
                           input logic [T_W-1:0] want);
    int gap;
    gap = sender_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.norm_time <= stamp;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    progress_q.insert(progress_q.size(),
                      known ? want : scale_time(stamp, cur_mode, cur_accel));
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] mode_wr, input logic [31:0] accel_wr);
    sample_ch.valid <= 1'b0;
    while (progress_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write({REG_MODE, 2'b00}, mode_wr);
    apb_write({REG_ACCEL, 2'b00}, accel_wr);
    cur_mode      = mode_wr[1:0];
    cur_accel     = accel_wr[TA_W-1:0];
    last_mode_wr  = mode_wr;
    last_accel_wr = accel_wr;
  endtask

  // result side: random hold-off per item, plus one long hold on request
  initial begin
    int gap;
    logic held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold > 0 && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
      end else begin
        gap = receiver_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (progress_q.size() == 0) begin
        $display("%0t: unexpected progress item, expected none actual %0d",
                 $time, result_ch.progress);
        errors++;
      end else begin
        if (result_ch.progress !== progress_q[0]) begin
          $display("%0t: progress mismatch, expected %0d actual %0d",
                   $time, progress_q[0], result_ch.progress);
          errors++;
        end
        void'(progress_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("motion_time_scaling_profile_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    cur_mode      = MODE_LINEAR;
    cur_accel     = ACCEL_RESET;
    last_mode_wr  = 32'(MODE_LINEAR);
    last_accel_wr = 32'(ACCEL_RESET);
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.norm_time <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset settings first
    for (row = 0; row < STEP_COUNT; row++) begin
      if (STEPS[row].mode_wr != last_mode_wr || STEPS[row].accel_wr != last_accel_wr)
        apply_config(STEPS[row].mode_wr, STEPS[row].accel_wr);
      send_time(STEPS[row].stamp, STEPS[row].known, STEPS[row].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          pick_mode  = MODE_TRAPEZOID;
          pick_accel = '0;
        end
        1: begin
          pick_mode  = MODE_TRAPEZOID;
          pick_accel = '1;
        end
        2: begin
          pick_mode  = MODE_MIN_JERK;
          pick_accel = TA_W'($urandom());
        end
        default: begin
          pick_mode = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 7))
            0: pick_accel = '0;
            1: pick_accel = TA_W'(int'(TA_MIN) - 1);
            2: pick_accel = TA_MIN;
            3: pick_accel = TA_MAX;
            4: pick_accel = TA_W'(int'(TA_MAX) + 1);
            5: pick_accel = '1;
            default: pick_accel = TA_W'($urandom());
          endcase
        end
      endcase
      wr_word = $urandom();
      wr_word[1:0] = pick_mode;
      apply_config(wr_word, {16'($urandom()), pick_accel});
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // back up the pipeline until the input stalls
        cur_mode      = pick_mode;
        sender_idle   = 1'b0;
        long_hold     = 400;
      end
      for (item = 0; item < PHASE_ITEMS; item++)
        send_time(pick_time(), 1'b0, '0);
    end
    sample_ch.valid <= 1'b0;

    while (progress_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && progress_q.size() == 0) begin
      $display("motion_time_scaling_profile_core_test OK");
    end else begin
      $display("motion_time_scaling_profile_core_test NOT OK");
    end
    $finish;
  end

endmodule
